[rtl/point_geometric_transform_assert.svh]
// ----------------------------------------------------------------------------
// point_geometric_transform_assert
// Assertion macros used by the checker file of the point transform.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef POINT_GEOMETRIC_TRANSFORM_ASSERT_SVH
`define POINT_GEOMETRIC_TRANSFORM_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define PGT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point transform assertion failed");

// Implication with a fixed delay in cycles, off while reset is high.
`define PGT_ASSERT_AFTER(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("point transform assertion failed");

`endif

[rtl/pgt_pkg.sv]
// ----------------------------------------------------------------------------
// pgt_pkg
// Shared constants and types of the 2D point transform pipeline.
// ----------------------------------------------------------------------------
package pgt_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // transform_mode codes
  localparam logic [1:0] MODE_CROP    = 2'd0;
  localparam logic [1:0] MODE_AFFINE  = 2'd1;
  localparam logic [1:0] MODE_SIMILAR = 2'd2;

  // configuration register indexes
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_DIR  = 1'b1;

  // control that travels with each item through the divider stages
  typedef struct packed {
    logic valid;
    logic bypass;  // result is already final, no quotient to build
    logic neg;     // quotient sign
    logic ovf;     // quotient magnitude at least 2^COORD_WIDTH
    logic dz;      // zero divisor seen
  } pgt_ctl_t;

endpackage

[rtl/pgt_div_pipe.sv]
// ----------------------------------------------------------------------------
// pgt_div_pipe
// Restoring divider, one quotient bit per stage, with sign and saturation.
// ----------------------------------------------------------------------------
module pgt_div_pipe #(
  parameter int W  = pgt_pkg::COORD_WIDTH_DEF,
  parameter int RW = 3 * pgt_pkg::COORD_WIDTH_DEF + 3,
  parameter int DW = 2 * pgt_pkg::COORD_WIDTH_DEF + 3
) (
  input  logic              clk,
  input  logic              rst,
  input  pgt_pkg::pgt_ctl_t in_ctl,
  input  logic [RW-1:0]     in_rem,
  input  logic [DW-1:0]     in_den,
  input  logic [W-1:0]      in_q,
  output pgt_pkg::pgt_ctl_t out_ctl,
  output logic [W-1:0]      out_val
);

  localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

  pgt_pkg::pgt_ctl_t ctl [1:W];
  logic [RW-1:0]     rem [1:W];
  logic [DW-1:0]     den [1:W];
  logic [W-1:0]      q   [1:W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int B = W - 1 - s;
    pgt_pkg::pgt_ctl_t ctl_in;
    logic [RW-1:0]     rem_in;
    logic [DW-1:0]     den_in;
    logic [W-1:0]      q_in;
    logic [RW-1:0]     dsh;
    logic              take;

    if (s == 0) begin : g_first
      assign ctl_in = in_ctl;
      assign rem_in = in_rem;
      assign den_in = in_den;
      assign q_in   = in_q;
    end else begin : g_next
      assign ctl_in = ctl[s];
      assign rem_in = rem[s];
      assign den_in = den[s];
      assign q_in   = q[s];
    end

    always_comb begin
      dsh  = RW'(den_in) << B;
      take = !ctl_in.bypass && !ctl_in.ovf && (rem_in >= dsh);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1].valid <= 1'b0;
      end else begin
        ctl[s+1] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      rem[s+1] <= take ? rem_in - dsh : rem_in;
      den[s+1] <= den_in;
      q[s+1]   <= q_in | (W'(take) << B);
    end
  end

  // apply sign and clamp to the signed coordinate range; bypassed items pass unchanged
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl <= ctl[W];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl[W].bypass) begin
      out_val <= q[W];
    end else if (ctl[W].neg) begin
      out_val <= (ctl[W].ovf || q[W] > MIN_W) ? MIN_W : -q[W];
    end else begin
      out_val <= (ctl[W].ovf || q[W] >= MIN_W) ? MAX_W : q[W];
    end
  end

endmodule

[rtl/point_geometric_transform.sv]
// ----------------------------------------------------------------------------
// point_geometric_transform
// Maps a 2D point through a per-sample crop, affine or similarity transform,
// or through its closed-form inverse, in signed fixed point.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  --------  --------------------  ---------------------------------------
//  input     start, busy           point_x, point_y, coef_0 .. coef_5
//  result    done (one cycle)      out_x, out_y, divide_by_zero
//  config    cfg_write             cfg_index, cfg_data
//
// One point is taken every cycle while busy is low; each result is strobed on
// done and taken in order, after passing stages 1 to 6, the divider pipeline,
// which resolves one quotient bit per stage for each coordinate, and the
// divider's output register.
// Reset clears the valid bits of every stage; busy is high only during reset.
// The receiver cannot stall, so the pipeline advances on every clock.
module point_geometric_transform #(
  parameter int COORD_WIDTH = pgt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = pgt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] coef_0,
  input  logic signed [COORD_WIDTH-1:0] coef_1,
  input  logic signed [COORD_WIDTH-1:0] coef_2,
  input  logic signed [COORD_WIDTH-1:0] coef_3,
  input  logic signed [COORD_WIDTH-1:0] coef_4,
  input  logic signed [COORD_WIDTH-1:0] coef_5,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [1:0]                    cfg_data,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic                          divide_by_zero
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W + 2;   // one product
  localparam int SW  = 2 * W + 4;   // numerator sum
  localparam int DW  = 2 * W + 3;   // divisor sum
  localparam int NSW = SW + F;
  localparam int DSW = DW + W;
  localparam int RW  = (NSW > DSW) ? NSW : DSW;

  localparam logic signed [SW-1:0] SAT_HI = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [1:0] transform_mode;
  logic       apply_forward;

  always_ff @(posedge clk) begin
    if (rst) begin
      transform_mode <= pgt_pkg::MODE_CROP;
      apply_forward  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        pgt_pkg::REG_MODE: transform_mode <= cfg_data;
        pgt_pkg::REG_DIR:  apply_forward  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // --------------------------------------------------------------------------
  // stage 1: pick operand pairs for every product
  // x numerator uses pairs 0..3, y numerator 4..7; divisor x pairs 0..1,
  // divisor y pairs 2..3. Inverse crop feeds the difference times one.
  // --------------------------------------------------------------------------
  logic signed [W:0] xx, yy, k0, k1, k2, k3, k4, k5, one;
  logic signed [W:0] op_a [0:7];
  logic signed [W:0] op_b [0:7];
  logic signed [W:0] op_d [0:3];
  logic signed [W:0] op_e [0:3];
  logic signed [W-1:0] off_x, off_y;
  logic is_div;

  always_comb begin
    xx  = {point_x[W-1], point_x};
    yy  = {point_y[W-1], point_y};
    k0  = {coef_0[W-1], coef_0};
    k1  = {coef_1[W-1], coef_1};
    k2  = {coef_2[W-1], coef_2};
    k3  = {coef_3[W-1], coef_3};
    k4  = {coef_4[W-1], coef_4};
    k5  = {coef_5[W-1], coef_5};
    one = (W+1)'(1);
    for (int i = 0; i < 8; i++) begin
      op_a[i] = '0;
      op_b[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      op_d[i] = '0;
      op_e[i] = '0;
    end
    off_x  = '0;
    off_y  = '0;
    is_div = 1'b0;
    case (transform_mode)
      pgt_pkg::MODE_CROP: begin
        if (apply_forward) begin
          op_a[0] = xx; op_b[0] = k2; off_x = coef_3;
          op_a[4] = yy; op_b[4] = k0; off_y = coef_1;
        end else begin
          is_div  = 1'b1;
          op_a[0] = xx - k3; op_b[0] = one;
          op_a[4] = yy - k1; op_b[4] = one;
          op_d[0] = k2; op_e[0] = one;
          op_d[2] = k0; op_e[2] = one;
        end
      end
      pgt_pkg::MODE_AFFINE: begin
        if (apply_forward) begin
          op_a[0] = xx; op_b[0] = k4;
          op_a[1] = yy; op_b[1] = k3; off_x = coef_5;
          op_a[4] = xx; op_b[4] = k1;
          op_a[5] = yy; op_b[5] = k0; off_y = coef_2;
        end else begin
          is_div  = 1'b1;
          op_a[0] = xx;  op_b[0] = k0;
          op_a[1] = -yy; op_b[1] = k3;
          op_a[2] = k2;  op_b[2] = k3;
          op_a[3] = -k0; op_b[3] = k5;
          op_a[4] = xx;  op_b[4] = k1;
          op_a[5] = -yy; op_b[5] = k4;
          op_a[6] = k2;  op_b[6] = k4;
          op_a[7] = -k1; op_b[7] = k5;
          op_d[0] = k0;  op_e[0] = k4;
          op_d[1] = -k1; op_e[1] = k3;
          op_d[2] = -k0; op_e[2] = k4;
          op_d[3] = k1;  op_e[3] = k3;
        end
      end
      pgt_pkg::MODE_SIMILAR: begin
        if (apply_forward) begin
          op_a[0] = xx;  op_b[0] = k0;
          op_a[1] = -yy; op_b[1] = k1; off_x = coef_3;
          op_a[4] = xx;  op_b[4] = k1;
          op_a[5] = yy;  op_b[5] = k0; off_y = coef_2;
        end else begin
          is_div  = 1'b1;
          op_a[0] = xx;  op_b[0] = k0;
          op_a[1] = yy;  op_b[1] = k1;
          op_a[2] = -k0; op_b[2] = k3;
          op_a[3] = -k2; op_b[3] = k1;
          op_a[4] = xx;  op_b[4] = k1;
          op_a[5] = -yy; op_b[5] = k0;
          op_a[6] = k2;  op_b[6] = k0;
          op_a[7] = -k1; op_b[7] = k3;
          op_d[0] = k0;  op_e[0] = k0;
          op_d[1] = k1;  op_e[1] = k1;
          op_d[2] = -k0; op_e[2] = k0;
          op_d[3] = -k1; op_e[3] = k1;
        end
      end
      default: ;  // unused mode: everything zero, result zero
    endcase
  end

  logic              s1_valid, s1_fwd, s1_div;
  logic signed [W:0] s1_a [0:7];
  logic signed [W:0] s1_b [0:7];
  logic signed [W:0] s1_d [0:3];
  logic signed [W:0] s1_e [0:3];
  logic signed [W-1:0] s1_offx, s1_offy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_a    <= op_a;
    s1_b    <= op_b;
    s1_d    <= op_d;
    s1_e    <= op_e;
    s1_offx <= off_x;
    s1_offy <= off_y;
    s1_fwd  <= apply_forward;
    s1_div  <= is_div;
  end

  // --------------------------------------------------------------------------
  // stage 2: products
  // --------------------------------------------------------------------------
  logic               s2_valid, s2_fwd, s2_div;
  logic signed [PW-1:0] s2_p  [0:7];
  logic signed [PW-1:0] s2_dp [0:3];
  logic signed [W-1:0]  s2_offx, s2_offy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      s2_p[i] <= s1_a[i] * s1_b[i];
    end
    for (int i = 0; i < 4; i++) begin
      s2_dp[i] <= s1_d[i] * s1_e[i];
    end
    s2_offx <= s1_offx;
    s2_offy <= s1_offy;
    s2_fwd  <= s1_fwd;
    s2_div  <= s1_div;
  end

  // --------------------------------------------------------------------------
  // stage 3: partial sums; forward adds offset and rounding half
  // --------------------------------------------------------------------------
  logic                 s3_valid, s3_fwd, s3_div;
  logic signed [SW-1:0] s3_xa, s3_xb, s3_ya, s3_yb;
  logic signed [DW-1:0] s3_dx, s3_dy;
  logic signed [SW-1:0] half;

  always_comb begin
    half = $signed(SW'(s2_fwd) << (F - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_xa  <= SW'(s2_p[0]) + SW'(s2_p[1]);
    s3_xb  <= SW'(s2_p[2]) + SW'(s2_p[3]) + (SW'(s2_offx) <<< F) + half;
    s3_ya  <= SW'(s2_p[4]) + SW'(s2_p[5]);
    s3_yb  <= SW'(s2_p[6]) + SW'(s2_p[7]) + (SW'(s2_offy) <<< F) + half;
    s3_dx  <= DW'(s2_dp[0]) + DW'(s2_dp[1]);
    s3_dy  <= DW'(s2_dp[2]) + DW'(s2_dp[3]);
    s3_fwd <= s2_fwd;
    s3_div <= s2_div;
  end

  // --------------------------------------------------------------------------
  // stage 4: full numerators
  // --------------------------------------------------------------------------
  logic                 s4_valid, s4_fwd, s4_div;
  logic signed [SW-1:0] s4_nx, s4_ny;
  logic signed [DW-1:0] s4_dx, s4_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_nx  <= s3_xa + s3_xb;
    s4_ny  <= s3_ya + s3_yb;
    s4_dx  <= s3_dx;
    s4_dy  <= s3_dy;
    s4_fwd <= s3_fwd;
    s4_div <= s3_div;
  end

  // --------------------------------------------------------------------------
  // stage 5: finish forward results, take magnitudes and signs for division
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] shx, shy;
  logic [W-1:0]         fwd_x, fwd_y;
  logic                 dz5;

  always_comb begin
    shx = s4_nx >>> F;
    shy = s4_ny >>> F;
    if (shx > SAT_HI)      fwd_x = SAT_HI[W-1:0];
    else if (shx < SAT_LO) fwd_x = SAT_LO[W-1:0];
    else                   fwd_x = shx[W-1:0];
    if (shy > SAT_HI)      fwd_y = SAT_HI[W-1:0];
    else if (shy < SAT_LO) fwd_y = SAT_LO[W-1:0];
    else                   fwd_y = shy[W-1:0];
    dz5 = s4_div && (s4_dx == '0 || s4_dy == '0);
  end

  logic          s5_valid, s5_dz, s5_bypass, s5_negx, s5_negy;
  logic [SW-1:0] s5_mnx, s5_mny;
  logic [DW-1:0] s5_mdx, s5_mdy;
  logic [W-1:0]  s5_qx, s5_qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_mnx    <= s4_nx[SW-1] ? SW'(-s4_nx) : SW'(s4_nx);
    s5_mny    <= s4_ny[SW-1] ? SW'(-s4_ny) : SW'(s4_ny);
    s5_mdx    <= s4_dx[DW-1] ? DW'(-s4_dx) : DW'(s4_dx);
    s5_mdy    <= s4_dy[DW-1] ? DW'(-s4_dy) : DW'(s4_dy);
    s5_negx   <= s4_nx[SW-1] ^ s4_dx[DW-1];
    s5_negy   <= s4_ny[SW-1] ^ s4_dy[DW-1];
    s5_dz     <= dz5;
    s5_bypass <= !s4_div || dz5;
    // forward value rides the quotient slot; zero for dz and the unused mode
    s5_qx     <= s4_fwd ? fwd_x : '0;
    s5_qy     <= s4_fwd ? fwd_y : '0;
  end

  // --------------------------------------------------------------------------
  // stage 6: scale numerators and flag quotients beyond COORD_WIDTH bits
  // --------------------------------------------------------------------------
  pgt_pkg::pgt_ctl_t s6_ctlx, s6_ctly;
  logic [RW-1:0]     s6_remx, s6_remy;
  logic [DW-1:0]     s6_denx, s6_deny;
  logic [W-1:0]      s6_qx, s6_qy;
  logic [RW-1:0]     remx5, remy5;

  always_comb begin
    remx5 = RW'(s5_mnx) << F;
    remy5 = RW'(s5_mny) << F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_ctlx.valid <= 1'b0;
      s6_ctly.valid <= 1'b0;
    end else begin
      s6_ctlx.valid <= s5_valid;
      s6_ctly.valid <= s5_valid;
    end
    s6_ctlx.bypass <= s5_bypass;
    s6_ctlx.neg    <= s5_negx;
    s6_ctlx.ovf    <= remx5 >= (RW'(s5_mdx) << W);
    s6_ctlx.dz     <= s5_dz;
    s6_ctly.bypass <= s5_bypass;
    s6_ctly.neg    <= s5_negy;
    s6_ctly.ovf    <= remy5 >= (RW'(s5_mdy) << W);
    s6_ctly.dz     <= s5_dz;
  end

  always_ff @(posedge clk) begin
    s6_remx <= remx5;
    s6_remy <= remy5;
    s6_denx <= s5_mdx;
    s6_deny <= s5_mdy;
    s6_qx   <= s5_qx;
    s6_qy   <= s5_qy;
  end

  // --------------------------------------------------------------------------
  // quotient pipelines, one per coordinate
  // --------------------------------------------------------------------------
  pgt_pkg::pgt_ctl_t cx, cy;
  logic [W-1:0]      vx, vy;

  pgt_div_pipe #(.W(W), .RW(RW), .DW(DW)) u_div_x (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (s6_ctlx),
    .in_rem  (s6_remx),
    .in_den  (s6_denx),
    .in_q    (s6_qx),
    .out_ctl (cx),
    .out_val (vx)
  );

  pgt_div_pipe #(.W(W), .RW(RW), .DW(DW)) u_div_y (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (s6_ctly),
    .in_rem  (s6_remy),
    .in_den  (s6_deny),
    .in_q    (s6_qy),
    .out_ctl (cy),
    .out_val (vy)
  );

  // both lanes move in lockstep; the strobe needs both
  assign done           = cx.valid && cy.valid;
  assign out_x          = $signed(vx);
  assign out_y          = $signed(vy);
  assign divide_by_zero = cx.dz || cy.dz;

endmodule

[rtl/pgt_checker.sv]
// ----------------------------------------------------------------------------
// pgt_checker
// Port-level checks of the point transform: latency and zero-divisor results.
// ----------------------------------------------------------------------------
`include "point_geometric_transform_assert.svh"

module pgt_checker #(
  parameter int COORD_WIDTH = pgt_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input logic [COORD_WIDTH-1:0] out_x,
  input logic [COORD_WIDTH-1:0] out_y,
  input logic                   divide_by_zero
);

  // transfer edge to the edge that takes the result
  localparam int LAT = COORD_WIDTH + 7;

  `PGT_ASSERT_AFTER(a_latency, start && !busy, LAT, done)
  `PGT_ASSERT_IMPL(a_no_orphan, done, $past(start && !busy, LAT))
  `PGT_ASSERT_IMPL(a_dz_zero, done && divide_by_zero, out_x == '0 && out_y == '0)

endmodule

bind point_geometric_transform pgt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pgt_checker (.*);
